/* rtl/assert_macros.svh */
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge while out of reset
`define SLID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising clock edge, reset included
`define SLID_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/slid_pkg.sv */
package slid_pkg;

  localparam int DATA_W    = 32;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 6;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

endpackage

/* rtl/slid_mem.sv */
module slid_mem #(
  parameter int Depth = 32,
  parameter int Aw    = 5
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [Aw-1:0]               waddr_i,
  input  logic [slid_pkg::DATA_W-1:0] wdata_i,
  input  logic [Aw-1:0]               raddr_i,
  output logic [slid_pkg::DATA_W-1:0] rdata_o
);
  import slid_pkg::*;

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sorted_list_insert_delete.sv */
// insert: entries not below the value move up one place, then the value is written in;
// delete: every entry is read, the first match goes; read out: one word per entry, ascending
// full, empty and unused requests are answered from idle; else the word follows the last busy cycle
// busy_o is high while an accepted request is in progress and is low when its final word appears
// results are one-cycle strobes on valid_o; the receiver cannot stall them
// async active-low reset empties the list; entry memory is not cleared
module sorted_list_insert_delete #(
  parameter int CAPACITY = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [slid_pkg::REQ_W-1:0]           req_type_i,
  input  logic signed [slid_pkg::DATA_W-1:0]   value_i,
  output logic                                 busy_o,
  output logic                                 valid_o,
  output logic [slid_pkg::STATUS_W-1:0]        status_o,
  output logic signed [slid_pkg::DATA_W-1:0]   entry_value_o,
  output logic [slid_pkg::CNT_OUT_W-1:0]       count_o,
  output logic                                 last_o
);
  import slid_pkg::*;

  `include "assert_macros.svh"

  localparam int Aw = $clog2(CAPACITY);
  localparam int Cw = $clog2(CAPACITY + 1);
  localparam logic [Cw-1:0] CapCnt = Cw'(CAPACITY);
  localparam logic [Cw-1:0] One    = Cw'(1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS_RD = 3'd1;
  localparam logic [2:0] S_INS_EV = 3'd2;
  localparam logic [2:0] S_DEL_RD = 3'd3;
  localparam logic [2:0] S_DEL_EV = 3'd4;
  localparam logic [2:0] S_OUT_RD = 3'd5;
  localparam logic [2:0] S_OUT_EV = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [Cw-1:0]       n_q, n_d;
  logic [Cw-1:0]       idx_q, idx_d;
  logic                found_q, found_d;
  logic [DATA_W-1:0]   val_q, val_d;

  logic                ovalid_q, ovalid_d;
  logic [STATUS_W-1:0] ostatus_q, ostatus_d;
  logic [DATA_W-1:0]   ovalue_q, ovalue_d;
  logic [Cw-1:0]       ocnt_q, ocnt_d;
  logic                olast_q, olast_d;

  logic                mem_we;
  logic [Aw-1:0]       mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic [Aw-1:0]       mem_raddr;
  logic [DATA_W-1:0]   mem_rdata;

  logic [Cw-1:0]       idx_dec;
  logic [Cw-1:0]       idx_inc;

  assign idx_dec = idx_q - One;
  assign idx_inc = idx_q + One;

  slid_mem #(
    .Depth (CAPACITY),
    .Aw    (Aw)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    idx_d     = idx_q;
    found_d   = found_q;
    val_d     = val_q;
    ovalid_d  = 1'b0;
    ostatus_d = ST_OK;
    ovalue_d  = '0;
    ocnt_d    = n_q;
    olast_d   = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = idx_q[Aw-1:0];
    mem_wdata = val_q;
    mem_raddr = idx_q[Aw-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          val_d = value_i;
          case (req_type_i)
            REQ_INSERT: begin
              if (n_q == CapCnt) begin
                ovalid_d  = 1'b1;
                ostatus_d = ST_FULL;
              end else begin
                idx_d   = n_q;
                state_d = S_INS_RD;
              end
            end
            REQ_DELETE: begin
              idx_d   = '0;
              found_d = 1'b0;
              state_d = S_DEL_RD;
            end
            REQ_READ: begin
              if (n_q == '0) begin
                ovalid_d  = 1'b1;
                ostatus_d = ST_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = S_OUT_RD;
              end
            end
            default: begin
              ovalid_d = 1'b1;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (idx_q == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = val_q;
          n_d       = n_q + One;
          ovalid_d  = 1'b1;
          ocnt_d    = n_q + One;
          state_d   = S_IDLE;
        end else begin
          mem_raddr = idx_dec[Aw-1:0];
          state_d   = S_INS_EV;
        end
      end
      S_INS_EV: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[Aw-1:0];
        if ($signed(mem_rdata) < $signed(val_q)) begin
          mem_wdata = val_q;
          n_d       = n_q + One;
          ovalid_d  = 1'b1;
          ocnt_d    = n_q + One;
          state_d   = S_IDLE;
        end else begin
          mem_wdata = mem_rdata;
          idx_d     = idx_dec;
          state_d   = S_INS_RD;
        end
      end
      S_DEL_RD: begin
        if (idx_q == n_q) begin
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
          if (found_q) begin
            n_d    = n_q - One;
            ocnt_d = n_q - One;
          end else begin
            ostatus_d = ST_NOTFOUND;
          end
        end else begin
          mem_raddr = idx_q[Aw-1:0];
          state_d   = S_DEL_EV;
        end
      end
      S_DEL_EV: begin
        if (found_q) begin
          mem_we    = 1'b1;
          mem_waddr = idx_dec[Aw-1:0];
          mem_wdata = mem_rdata;
        end else if (mem_rdata == val_q) begin
          found_d = 1'b1;
        end
        idx_d   = idx_inc;
        state_d = S_DEL_RD;
      end
      S_OUT_RD: begin
        mem_raddr = idx_q[Aw-1:0];
        state_d   = S_OUT_EV;
      end
      S_OUT_EV: begin
        ovalid_d = 1'b1;
        ovalue_d = mem_rdata;
        olast_d  = (idx_inc == n_q);
        idx_d    = idx_inc;
        state_d  = (idx_inc == n_q) ? S_IDLE : S_OUT_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      n_q      <= '0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      n_q      <= n_d;
      idx_q    <= idx_d;
      found_q  <= found_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    ostatus_q <= ostatus_d;
    ovalue_q  <= ovalue_d;
    ocnt_q    <= ocnt_d;
    olast_q   <= olast_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign valid_o       = ovalid_q;
  assign status_o      = ostatus_q;
  assign entry_value_o = ovalue_q;
  assign count_o       = CNT_OUT_W'(ocnt_q);
  assign last_o        = olast_q;

  `SLID_ASSERT(a_count_bound, n_q <= CapCnt, "entry count above capacity")
  `SLID_ASSERT(a_full_at_cap, valid_o && status_o == ST_FULL |-> ocnt_q == CapCnt,
               "full reported below capacity")
  `SLID_ASSERT(a_empty_zero, valid_o && status_o == ST_EMPTY |-> ocnt_q == '0,
               "empty reported with entries stored")
  `SLID_ASSERT(a_more_words, valid_o && !last_o |-> busy_o, "read out stopped before last word")
  `SLID_ASSERT(a_idle_no_write, state_q == S_IDLE |-> !mem_we, "entry write while idle")
  `SLID_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !valid_o && !busy_o, "activity during reset")

endmodule

/* tb/sorted_list_insert_delete_tb.sv */
`timescale 1ns / 1ps

module sorted_list_insert_delete_tb;
  import slid_pkg::*;

  localparam int CAPACITY = 32;
  localparam int ITEMS = 380;
  localparam int MAX_GAP = 6;
  localparam int DRAIN_CYCLES = 4 * CAPACITY + 16;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [STATUS_W-1:0]           status;
    logic signed [DATA_W-1:0]      value;
    logic [CNT_OUT_W-1:0]          count;
    logic                          last;
  } slid_word_t;

  typedef struct {
    logic [REQ_W-1:0]         req;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    logic [STATUS_W-1:0]      status;
    logic [CNT_OUT_W-1:0]     count;
  } dir_row_t;

  localparam int N_DIR = 18;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic [REQ_W-1:0]              req_type_i;
  logic signed [DATA_W-1:0]      value_i;
  logic                          busy_o;
  logic                          valid_o;
  logic [STATUS_W-1:0]           status_o;
  logic signed [DATA_W-1:0]      entry_value_o;
  logic [CNT_OUT_W-1:0]          count_o;
  logic                          last_o;

  logic signed [DATA_W-1:0] sorted_q[$];
  slid_word_t               word_exp_q[$];

  int  errors;
  int  n_items;
  int  n_words;
  int  n_full;
  int  n_notfound;
  int  n_empty;
  int  n_unused;
  int  peak_fill;
  bit  burst_mode;

  dir_row_t dir_rows [N_DIR] = '{
    '{REQ_READ,   32'sd0,   1'b1, ST_EMPTY,    6'd0},
    '{REQ_DELETE, 32'sd5,   1'b1, ST_NOTFOUND, 6'd0},
    '{REQ_UNUSED, 32'sd0,   1'b1, ST_OK,       6'd0},
    '{REQ_INSERT, VAL_MAX,  1'b1, ST_OK,       6'd1},
    '{REQ_INSERT, VAL_MIN,  1'b1, ST_OK,       6'd2},
    '{REQ_INSERT, 32'sd0,   1'b1, ST_OK,       6'd3},
    '{REQ_INSERT, -32'sd1,  1'b1, ST_OK,       6'd4},
    '{REQ_INSERT, 32'sd0,   1'b1, ST_OK,       6'd5},
    '{REQ_INSERT, VAL_MIN,  1'b1, ST_OK,       6'd6},
    '{REQ_INSERT, 32'sh5555_5555, 1'b1, ST_OK, 6'd7},
    '{REQ_INSERT, 32'shAAAA_AAAA, 1'b1, ST_OK, 6'd8},
    '{REQ_READ,   32'sd1234, 1'b0, ST_OK,      6'd0},
    '{REQ_DELETE, 32'sd0,   1'b1, ST_OK,       6'd7},
    '{REQ_DELETE, VAL_MAX,  1'b1, ST_OK,       6'd6},
    '{REQ_DELETE, 32'sd12345, 1'b1, ST_NOTFOUND, 6'd6},
    '{REQ_UNUSED, -32'sd1,  1'b1, ST_OK,       6'd6},
    '{REQ_DELETE, VAL_MIN,  1'b1, ST_OK,       6'd5},
    '{REQ_READ,   -32'sd1,  1'b0, ST_OK,       6'd0}
  };

  sorted_list_insert_delete #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .req_type_i    (req_type_i),
    .value_i       (value_i),
    .busy_o        (busy_o),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .entry_value_o (entry_value_o),
    .count_o       (count_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // sorted store update and expected words for one accepted request
  function automatic void predict_request(input logic [REQ_W-1:0] rt,
                                          input logic signed [DATA_W-1:0] v,
                                          input bit typed,
                                          input logic [STATUS_W-1:0] t_status,
                                          input logic [CNT_OUT_W-1:0] t_count);
    int pos;
    slid_word_t w;
    pos = 0;
    w = '{status: ST_OK, value: '0, count: '0, last: 1'b1};
    case (rt)
      REQ_INSERT: begin
        if (sorted_q.size() >= CAPACITY) begin
          w.status = ST_FULL;
          n_full++;
        end else begin
          while (pos < sorted_q.size() && sorted_q[pos] < v) pos++;
          sorted_q.insert(pos, v);
        end
      end
      REQ_DELETE: begin
        while (pos < sorted_q.size() && sorted_q[pos] != v) pos++;
        if (pos >= sorted_q.size()) begin
          w.status = ST_NOTFOUND;
          n_notfound++;
        end else begin
          sorted_q.delete(pos);
        end
      end
      REQ_READ: begin
        if (sorted_q.size() == 0) begin
          w.status = ST_EMPTY;
          n_empty++;
        end else begin
          for (int i = 0; i < sorted_q.size(); i++) begin
            w.value = sorted_q[i];
            w.count = CNT_OUT_W'(sorted_q.size());
            w.last = (i == sorted_q.size() - 1);
            word_exp_q.push_back(w);
          end
          return;
        end
      end
      default: n_unused++;
    endcase
    w.count = CNT_OUT_W'(sorted_q.size());
    if (typed) begin
      w.status = t_status;
      w.count = t_count;
    end
    if (sorted_q.size() > peak_fill) peak_fill = sorted_q.size();
    word_exp_q.push_back(w);
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] rt,
                              input logic signed [DATA_W-1:0] v,
                              input bit typed = 1'b0,
                              input logic [STATUS_W-1:0] t_status = ST_OK,
                              input logic [CNT_OUT_W-1:0] t_count = '0);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    req_type_i <= rt;
    value_i    <= v;
    do @(posedge clk_i); while (busy_o);
    predict_request(rt, v, typed, t_status, t_count);
    n_items++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3, 4: return $signed($urandom_range(0, 20)) - 32'sd10;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_delete_value();
    if (sorted_q.size() > 0 && $urandom_range(0, 3) != 0)
      return sorted_q[$urandom_range(0, sorted_q.size() - 1)];
    return pick_value();
  endfunction

  task automatic report_field(input string name, input logic [DATA_W-1:0] exp_v,
                              input logic [DATA_W-1:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  // results sampled mid-cycle, away from the edges the driver works on
  always @(negedge clk_i) begin
    slid_word_t exp_w;
    if (rst_ni && valid_o) begin
      n_words++;
      if (word_exp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got status %0d value %0h count %0d last %0b",
                 $time, status_o, entry_value_o, count_o, last_o);
      end else begin
        exp_w = word_exp_q.pop_front();
        report_field("status", exp_w.status, status_o);
        report_field("entry_value", exp_w.value, entry_value_o);
        report_field("count", exp_w.count, count_o);
        report_field("last", exp_w.last, last_o);
      end
    end
  end

  initial begin
    int r;
    int wait_cycles;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    req_type_i = REQ_INSERT;
    value_i    = '0;
    errors     = 0;
    n_items    = 0;
    n_words    = 0;
    n_full     = 0;
    n_notfound = 0;
    n_empty    = 0;
    n_unused   = 0;
    peak_fill  = 0;
    burst_mode = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_request(dir_rows[i].req, dir_rows[i].value, dir_rows[i].typed,
                   dir_rows[i].status, dir_rows[i].count);

    while (n_items < ITEMS) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: begin
          while (sorted_q.size() < CAPACITY) send_request(REQ_INSERT, pick_value());
          repeat ($urandom_range(1, 3)) send_request(REQ_INSERT, pick_value());
          send_request(REQ_READ, $urandom);
        end
        1: begin
          while (sorted_q.size() > 0) send_request(REQ_DELETE, pick_delete_value());
          send_request(REQ_DELETE, pick_value());
          send_request(REQ_READ, $urandom);
        end
        default: begin
          repeat (25) begin
            r = $urandom_range(0, 99);
            if (r < 45) send_request(REQ_INSERT, pick_value());
            else if (r < 80) send_request(REQ_DELETE, pick_delete_value());
            else if (r < 95) send_request(REQ_READ, $urandom);
            else send_request(REQ_UNUSED, $urandom);
          end
        end
      endcase
    end

    start_i <= 1'b0;
    wait_cycles = 0;
    while (word_exp_q.size() != 0 && wait_cycles < 100_000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (word_exp_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived", $time, word_exp_q.size());
    end

    $display("ran %0d requests and %0d result words, peak fill %0d of %0d",
             n_items, n_words, peak_fill, CAPACITY);
    $display("full rejects %0d, delete misses %0d, empty reads %0d, unused codes %0d",
             n_full, n_notfound, n_empty, n_unused);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
